// ===== hdl/u2u_pkg.sv =====
`default_nettype none
package u2u_pkg;

  // One input request: an ASCII hex character and the end-of-string mark.
  typedef struct packed {
    logic [7:0] hex_char;
    logic       end_of_input;
  } in_item_t;

  // One result: a UTF-8 byte or the end-of-string marker.
  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       byte_valid;
    logic       last_of_char;
    logic       string_done;
  } out_item_t;

  // Work handed from the front to the back: a finished code unit and/or an end marker.
  typedef struct packed {
    logic [15:0] code;
    logic        has_char;
    logic        has_end;
  } job_t;

  localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
  localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
  localparam logic [7:0]  LEAD2_MARK   = 8'hC0;
  localparam logic [7:0]  LEAD3_MARK   = 8'hE0;
  localparam logic [7:0]  CONT_MARK    = 8'h80;

  // Map an ASCII character to its hex value; anything else counts as zero.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  // Number of UTF-8 bytes for a non-zero code unit.
  function automatic logic [1:0] utf8_len(input logic [15:0] u);
    logic [1:0] n;
    if (u <= ONE_BYTE_MAX) begin
      n = 2'd1;
    end else if (u <= TWO_BYTE_MAX) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  // Byte number k (from 0) of the encoding of u, which is len bytes long.
  function automatic logic [7:0] utf8_byte_at(input logic [15:0] u, input logic [1:0] len,
                                               input logic [1:0] k);
    logic [7:0] b;
    b = 8'h00;
    case (len)
      2'd1: begin
        b = {1'b0, u[6:0]};
      end
      2'd2: begin
        if (k == 2'd0) b = LEAD2_MARK | {3'b000, u[10:6]};
        else b = CONT_MARK | {2'b00, u[5:0]};
      end
      2'd3: begin
        if (k == 2'd0) b = LEAD3_MARK | {4'h0, u[15:12]};
        else if (k == 2'd1) b = CONT_MARK | {2'b00, u[11:6]};
        else b = CONT_MARK | {2'b00, u[5:0]};
      end
      default: begin
        b = 8'h00;
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ucs2_hex_to_utf8.sv =====
// UCS-2 hex text to UTF-8 transcoder.
// Input channel: a request (hex_char, end_of_input) is taken at a clock edge where push
// is high and full is low. Four hex characters, high nibble first, form one code unit,
// which leaves as one to three UTF-8 bytes; the final byte carries last_of_char.
// A zero code unit ends the text and later characters produce nothing. A request
// marked end_of_input is handled as a character first, then a result with string_done
// follows and the collection state returns to reset.
// Output channel: the oldest result sits on result while empty is low and is taken at
// an edge where pop is high. The first result of a request passes the queue and then
// the output register. The front takes one request per cycle while full is low; the
// back emits one result per cycle while pop is high; four characters (at most three
// bytes) keep pace. The queue between front and back holds QUEUE_DEPTH jobs; when the
// receiver stalls, the queue fills and full rises, holding the sender off without
// losing anything. Reset (rst, synchronous) empties the queue and the output register
// and clears the collection state.
`default_nettype none
module ucs2_hex_to_utf8 import u2u_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  item,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      result
);

  job_t front_job;
  logic front_push;
  job_t head_job;
  logic q_empty;
  logic q_pop;
  logic accept;

  assign accept = push && !full;

  // Front: collect nibbles and classify finished code units.
  u2u_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job      (front_job),
    .job_push (front_push)
  );

  // Queue decoupling front from back.
  u2u_jobq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_push),
    .wr_job  (front_job),
    .rd_en   (q_pop),
    .rd_job  (head_job),
    .q_full  (full),
    .q_empty (q_empty)
  );

  // Back: emit the UTF-8 bytes and end markers one per cycle while the receiver pops.
  u2u_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_avail (!q_empty),
    .job_pop   (q_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire

// ===== hdl/u2u_front.sv =====
`default_nettype none
module u2u_front import u2u_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire in_item_t item,
  output job_t          job,
  output logic          job_push
);

  logic [1:0]  nib_cnt;
  logic [15:0] acc;
  logic        terminated;
  logic [15:0] acc_next;
  logic        group_done;
  logic        char_ok;

  // Shift the new nibble into the code unit being collected.
  assign acc_next   = {acc[11:0], hex_nibble(item.hex_char)};
  assign group_done = !terminated && (nib_cnt == 2'd3);
  assign char_ok    = group_done && (acc_next != 16'h0000);

  // A request produces work for the back only if it completes a character or ends the string.
  assign job.code     = acc_next;
  assign job.has_char = char_ok;
  assign job.has_end  = item.end_of_input;
  assign job_push     = accept && (char_ok || item.end_of_input);

  // Collection state; the end of the string returns everything to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      nib_cnt    <= 2'd0;
      acc        <= 16'h0000;
      terminated <= 1'b0;
    end else if (accept) begin
      if (item.end_of_input) begin
        nib_cnt    <= 2'd0;
        acc        <= 16'h0000;
        terminated <= 1'b0;
      end else if (!terminated) begin
        if (group_done) begin
          nib_cnt <= 2'd0;
          acc     <= 16'h0000;
          if (acc_next == 16'h0000) terminated <= 1'b1;
        end else begin
          nib_cnt <= nib_cnt + 2'd1;
          acc     <= acc_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/u2u_jobq.sv =====
`default_nettype none
module u2u_jobq import u2u_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  input  wire logic rd_en,
  output job_t      rd_job,
  output logic      q_full,
  output logic      q_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign rd_job  = slots[rd_ptr];

  // Storage for queued work.
  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_job;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == LAST_ADDR) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == LAST_ADDR) ? '0 : rd_ptr + 1'b1;
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/u2u_back.sv =====
`default_nettype none
module u2u_back import u2u_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t job,
  input  wire logic job_avail,
  output logic      job_pop,
  output out_item_t result,
  output logic      empty,
  input  wire logic pop
);

  logic [1:0] step;
  logic [1:0] nbytes;
  logic [2:0] total;
  logic       slot_free;
  logic       advance;
  logic       last_step;
  logic       out_valid;
  out_item_t  res_next;

  assign nbytes    = job.has_char ? utf8_len(job.code) : 2'd0;
  assign total     = {1'b0, nbytes} + {2'b00, job.has_end};
  assign last_step = ({1'b0, step} == (total - 3'd1));
  assign slot_free = !out_valid || pop;
  assign advance   = job_avail && slot_free;
  assign job_pop   = advance && last_step;
  assign empty     = !out_valid;

  // Select the byte for this step, or the end marker once the bytes are out.
  always_comb begin
    res_next = '0;
    if (step < nbytes) begin
      res_next.utf8_byte    = utf8_byte_at(job.code, nbytes, step);
      res_next.byte_valid   = 1'b1;
      res_next.last_of_char = (step == nbytes - 2'd1);
    end else begin
      res_next.string_done  = 1'b1;
    end
  end

  // Step counter through the results of the job at the head of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 2'd0;
    end else if (advance) begin
      step <= last_step ? 2'd0 : step + 2'd1;
    end
  end

  // Output register holding the oldest waiting result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= job_avail;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result <= res_next;
  end

endmodule
`default_nettype wire

// ===== bench/ucs2_hex_to_utf8_check.sv =====
`timescale 1ns / 1ps
module ucs2_hex_to_utf8_check import u2u_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire logic      full,
  input  wire in_item_t  item,
  input  wire logic      empty,
  input  wire logic      pop,
  input  wire out_item_t result,
  output int             failures,
  output int             outstanding,
  output int             bytes_seen,
  output int             strings_seen
);

  // Transcoder state as the block should hold it.
  logic [1:0]  digits_held;
  logic [15:0] unit_acc;
  logic        text_ended;

  // UTF-8 bytes and end markers still owed by the block, oldest first.
  out_item_t   utf8_owed[$];

  // Value of one ASCII hex digit; any other character is worth zero.
  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 10);
    end else if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 10);
    end
    return v;
  endfunction

  task automatic owe_byte(input logic [7:0] b, input logic last);
    utf8_owed.push_back('{utf8_byte: b, byte_valid: 1'b1, last_of_char: last,
                          string_done: 1'b0});
  endtask

  task automatic clear_text();
    digits_held = 2'd0;
    unit_acc    = 16'h0000;
    text_ended  = 1'b0;
  endtask

  // Work out the bytes one accepted request gives rise to.
  task automatic transcode(input in_item_t r);
    logic [15:0] u;
    if (!text_ended) begin
      u = {unit_acc[11:0], digit_value(r.hex_char)};
      unit_acc = u;
      if (digits_held == 2'd3) begin
        digits_held = 2'd0;
        unit_acc    = 16'h0000;
        if (u == 16'h0000) begin
          // A zero code unit ends the text and emits nothing.
          text_ended = 1'b1;
        end else if (u <= ONE_BYTE_MAX) begin
          owe_byte({1'b0, u[6:0]}, 1'b1);
        end else if (u <= TWO_BYTE_MAX) begin
          owe_byte(LEAD2_MARK | {3'b000, u[10:6]}, 1'b0);
          owe_byte(CONT_MARK | {2'b00, u[5:0]}, 1'b1);
        end else begin
          owe_byte(LEAD3_MARK | {4'h0, u[15:12]}, 1'b0);
          owe_byte(CONT_MARK | {2'b00, u[11:6]}, 1'b0);
          owe_byte(CONT_MARK | {2'b00, u[5:0]}, 1'b1);
        end
      end else begin
        digits_held = digits_held + 2'd1;
      end
    end
    // The end of the string drops any partial group and restarts collection.
    if (r.end_of_input) begin
      utf8_owed.push_back('{utf8_byte: 8'h00, byte_valid: 1'b0, last_of_char: 1'b0,
                            string_done: 1'b1});
      clear_text();
    end
  endtask

  // Compare each accepted result with the oldest owed one, then predict.
  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      clear_text();
      utf8_owed.delete();
      failures     = 0;
      bytes_seen   = 0;
      strings_seen = 0;
    end else begin
      if (pop && !empty) begin
        if (utf8_owed.size() == 0) begin
          $error("result with nothing owed: %p", result);
          failures++;
        end else begin
          want = utf8_owed.pop_front();
          if (result.utf8_byte !== want.utf8_byte) begin
            $error("utf8_byte: expected %02h, got %02h", want.utf8_byte, result.utf8_byte);
            failures++;
          end
          if (result.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, result.byte_valid);
            failures++;
          end
          if (result.last_of_char !== want.last_of_char) begin
            $error("last_of_char: expected %0b, got %0b", want.last_of_char,
                   result.last_of_char);
            failures++;
          end
          if (result.string_done !== want.string_done) begin
            $error("string_done: expected %0b, got %0b", want.string_done,
                   result.string_done);
            failures++;
          end
        end
        if (result.byte_valid === 1'b1) bytes_seen++;
        if (result.string_done === 1'b1) strings_seen++;
      end
      if (push && !full) begin
        transcode(item);
      end
    end
    outstanding = utf8_owed.size();
  end

endmodule

// ===== bench/ucs2_hex_to_utf8_test.sv =====
`timescale 1ns / 1ps
module ucs2_hex_to_utf8_test;
  import u2u_pkg::*;

  localparam int REQUESTS  = 250;
  localparam int CALM_FROM = 210;
  localparam int LONG_HOLD = 120;

  logic      clk = 1'b0;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  item;
  logic      empty;
  logic      pop;
  out_item_t result;

  int        failures;
  int        outstanding;
  int        bytes_seen;
  int        strings_seen;
  int        requests_sent = 0;
  logic      calm = 1'b0;
  logic      hold_pending = 1'b0;

  ucs2_hex_to_utf8 u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  ucs2_hex_to_utf8_check u_check (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .item         (item),
    .empty        (empty),
    .pop          (pop),
    .result       (result),
    .failures     (failures),
    .outstanding  (outstanding),
    .bytes_seen   (bytes_seen),
    .strings_seen (strings_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one request and hold it until the block takes it; sometimes pause afterwards.
  task automatic offer(input logic [7:0] c, input logic last);
    logic taken;
    push <= 1'b1;
    item <= '{hex_char: c, end_of_input: last};
    do begin
      @(posedge clk);
      taken = !full;
      @(negedge clk);
    end while (!taken);
    requests_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  task automatic send_text(input string s, input logic end_last);
    for (int i = 0; i < s.len(); i++) begin
      offer(s[i], end_last && (i == s.len() - 1));
    end
  endtask

  // A hex digit in either case, now and then replaced by an arbitrary character.
  function automatic logic [7:0] digit_char(input logic [3:0] v);
    logic [7:0] c;
    if ($urandom_range(0, 11) == 0) begin
      c = 8'($urandom_range(0, 255));
    end else if (v < 4'd10) begin
      c = 8'("0" + v);
    end else if ($urandom_range(0, 1) == 0) begin
      c = 8'("A" + v - 10);
    end else begin
      c = 8'("a" + v - 10);
    end
    return c;
  endfunction

  // A string of whole code units from all three byte lengths, sometimes a zero unit,
  // sometimes a broken group at the end; the last character carries the end mark.
  task automatic send_random_string();
    in_item_t    chars[$];
    logic [15:0] unit;
    int          pick;
    repeat ($urandom_range(0, 5)) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        unit = 16'h0000;
      end else if (pick < 7) begin
        unit = 16'($urandom_range(1, 127));
      end else if (pick < 13) begin
        unit = 16'($urandom_range(128, 2047));
      end else begin
        unit = 16'($urandom_range(2048, 65535));
      end
      for (int k = 3; k >= 0; k--) begin
        chars.push_back('{hex_char: digit_char(unit[4*k +: 4]), end_of_input: 1'b0});
      end
    end
    if (chars.size() == 0 || $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        chars.push_back('{hex_char: digit_char(4'($urandom)), end_of_input: 1'b0});
      end
    end
    chars[chars.size() - 1].end_of_input = 1'b1;
    foreach (chars[i]) begin
      offer(chars[i].hex_char, chars[i].end_of_input);
    end
  endtask

  // Receiver: pops in runs, stalls in bursts, and once holds off long enough to fill
  // the block.
  initial begin
    pop = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst  = 1'b1;
    push = 1'b0;
    item = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Range boundaries, both letter cases and characters just outside the hex digits,
    // ending on a partial group.
    send_text("/07F0:8007ff@800FfFf0", 1'b1);
    // A zero unit built from non-hex characters, then a character that is ignored.
    send_text("G", 1'b0);
    offer(8'h60, 1'b0);
    send_text("g0", 1'b0);
    offer(8'hFF, 1'b1);

    hold_pending = 1'b1;
    while (requests_sent < REQUESTS) begin
      if (requests_sent >= CALM_FROM) calm = 1'b1;
      send_random_string();
    end
    push <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d requests; checked %0d UTF-8 bytes and %0d string ends,",
             requests_sent, bytes_seen, strings_seen);
    $display("with random stalls on both sides and one %0d-cycle receiver hold-off.",
             LONG_HOLD);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
